// ----- hw/rtl/fir_full_convolution_assert.svh -----
// Assertion macros shared by the FIR convolution checker.
// Needs a clock and an active-low reset named at each use.
`ifndef FIR_FULL_CONVOLUTION_ASSERT_SVH
`define FIR_FULL_CONVOLUTION_ASSERT_SVH

// Property that must hold at every clock edge out of reset
`define FCV_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger
`define FCV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/fcv_pkg.sv -----
// Package for the full-convolution FIR filter: widths, register indexes
// and the tap count clamp. No dependencies.
package fcv_pkg;

	localparam int TAPS_DEF        = 8;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int SAMPLE_PORT_W   = 16;
	localparam int COEF_BITS       = 16;
	localparam int COEF_WORD_W     = 64;
	localparam int OUT_BITS        = 35;
	localparam int CNT_W           = 4;
	localparam int CFG_IDX_W       = 2;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TAP_COUNT   = 2'd0,
		REG_COEFFS_LOW  = 2'd1,
		REG_COEFFS_HIGH = 2'd2
	} cfg_reg_t;

	// Clamp the programmed tap count into 1..max_taps
	function automatic logic [CNT_W-1:0] sat_taps(input logic [CNT_W-1:0] raw,
			input logic [CNT_W-1:0] max_taps);
		logic [CNT_W-1:0] res;
		if (raw == '0) begin
			res = CNT_W'(1);
		end else if (raw > max_taps) begin
			res = max_taps;
		end else begin
			res = raw;
		end
		return res;
	endfunction

endpackage

// ----- hw/rtl/fir_full_convolution.sv -----
// Full-convolution integer FIR filter, top level.
// Depends on fcv_pkg.
//
// channel | dir | handshake            | payload
// --------+-----+----------------------+----------------------------------
// input   | in  | in_valid / in_stall  | sample[15:0], block_end
// result  | out | out_valid / out_stall| filtered[34:0], final_res
// config  | in  | cfg_valid / cfg_ready| cfg_index[1:0], cfg_data[63:0]
//
// One sample per cycle while in_stall is low; a result passes win_s1, prod_s2 and the result register.
// A sample with block_end adds tap_count-1 tail results, during which
// in_stall is high while the window sequencer feeds zeros.
// The pipeline advances as a whole whenever the result register is free;
// out_stall backs up to in_stall in the same cycle.
// Reset clears the delay line, tap_count to 1 and all coefficients.
module fir_full_convolution #(
	parameter int TAPS        = fcv_pkg::TAPS_DEF,
	parameter int SAMPLE_BITS = fcv_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [fcv_pkg::SAMPLE_PORT_W-1:0] sample,
	input  logic                              block_end,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [fcv_pkg::OUT_BITS-1:0]      filtered,
	output logic                              final_res,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fcv_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fcv_pkg::COEF_WORD_W-1:0]   cfg_data
);
	import fcv_pkg::*;

	localparam int TW     = $clog2(TAPS);
	localparam int PROD_W = COEF_BITS + SAMPLE_BITS;

	// Configuration registers
	logic [CNT_W-1:0]       tap_count_q;
	logic [COEF_WORD_W-1:0] coeffs_low_q;
	logic [COEF_WORD_W-1:0] coeffs_high_q;

	// Window sequencer state
	logic [SAMPLE_BITS-1:0] dl_q [TAPS-1];
	logic [TW-1:0]          tail_q;

	// Pipeline registers
	logic                          valid_s1;
	logic                          final_s1;
	logic signed [SAMPLE_BITS-1:0] win_s1 [TAPS];
	logic                          valid_s2;
	logic                          final_s2;
	logic signed [PROD_W-1:0]      prod_s2 [TAPS];
	logic                          out_valid_q;
	logic                          final_q;
	logic signed [OUT_BITS-1:0]    filtered_q;

	// Combinational
	logic [CNT_W-1:0]              taps;
	logic                          adv;
	logic                          tail_busy;
	logic                          accept;
	logic                          load;
	logic                          blk_last;
	logic [SAMPLE_BITS-1:0]        x_new;
	logic [SAMPLE_BITS-1:0]        win_next [TAPS];
	logic [TW-1:0]                 tail_next;
	logic [2*COEF_WORD_W-1:0]      coeff_all;
	logic signed [COEF_BITS-1:0]   coef [TAPS];
	logic signed [PROD_W-1:0]      prod_next [TAPS];
	logic signed [OUT_BITS-1:0]    sum_next;

	assign cfg_ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q   <= CNT_W'(1);
			coeffs_low_q  <= '0;
			coeffs_high_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_TAP_COUNT:   tap_count_q   <= cfg_data[CNT_W-1:0];
				REG_COEFFS_LOW:  coeffs_low_q  <= cfg_data;
				REG_COEFFS_HIGH: coeffs_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake and window selection
	always_comb begin
		taps      = sat_taps(tap_count_q, CNT_W'(TAPS));
		adv       = !out_valid_q || !out_stall;
		tail_busy = (tail_q != '0);
		in_stall  = !adv || tail_busy;
		accept    = in_valid && !in_stall;
		load      = adv && (accept || tail_busy);
		x_new     = accept ? sample[SAMPLE_BITS-1:0] : '0;
		// last output of a block: single tap with block_end, or last tail step
		blk_last  = accept ? (block_end && (taps == CNT_W'(1))) : (tail_q == TW'(1));
		win_next[0] = x_new;
		for (int k = 1; k < TAPS; k++) begin
			win_next[k] = (CNT_W'(k) < taps) ? dl_q[k-1] : '0;
		end
		if (accept && block_end && (taps != CNT_W'(1))) begin
			tail_next = TW'(taps - CNT_W'(1));
		end else if (adv && tail_busy) begin
			tail_next = tail_q - TW'(1);
		end else begin
			tail_next = tail_q;
		end
	end

	// Delay line, tail counter and window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAPS-1; k++) begin
				dl_q[k] <= '0;
			end
			tail_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			tail_q <= tail_next;
			if (adv) begin
				valid_s1 <= load;
			end
			if (load) begin
				if (blk_last) begin
					for (int k = 0; k < TAPS-1; k++) begin
						dl_q[k] <= '0;
					end
				end else begin
					dl_q[0] <= x_new;
					for (int k = 1; k < TAPS-1; k++) begin
						dl_q[k] <= dl_q[k-1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < TAPS; k++) begin
				win_s1[k] <= win_next[k];
			end
			final_s1 <= blk_last;
		end
	end

	// Coefficient split and tap products
	always_comb begin
		coeff_all = {coeffs_high_q, coeffs_low_q};
		for (int k = 0; k < TAPS; k++) begin
			coef[k]      = coeff_all[k*COEF_BITS +: COEF_BITS];
			prod_next[k] = PROD_W'(coef[k] * win_s1[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < TAPS; k++) begin
				prod_s2[k] <= prod_next[k];
			end
			final_s2 <= final_s1;
		end
	end

	// Sum of products into the result register
	always_comb begin
		sum_next = '0;
		for (int k = 0; k < TAPS; k++) begin
			sum_next = sum_next + OUT_BITS'(prod_s2[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			filtered_q <= sum_next;
			final_q    <= final_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;
	assign final_res = final_q;

endmodule

// ----- hw/rtl/fcv_chk.sv -----
// Port-level checker for the full-convolution FIR filter, bound to the top.
// Depends on fcv_pkg and fir_full_convolution_assert.svh.
`include "fir_full_convolution_assert.svh"

module fcv_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic [fcv_pkg::SAMPLE_PORT_W-1:0] sample,
	input logic                              block_end,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [fcv_pkg::OUT_BITS-1:0]      filtered,
	input logic                              final_res,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic [fcv_pkg::CFG_IDX_W-1:0]     cfg_index,
	input logic [fcv_pkg::COEF_WORD_W-1:0]   cfg_data
);
	import fcv_pkg::*;

	logic [CNT_W-1:0]           taps_q;
	logic [CNT_W-1:0]           taps;
	logic                       in_acc;
	logic                       in_hold;
	logic                       out_hold;
	logic                       tail_start;
	logic                       long_start;
	logic [SAMPLE_PORT_W:0]     in_word;
	logic [OUT_BITS:0]          out_word;

	// Track the programmed tap count from the config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q <= CNT_W'(1);
		end else if (cfg_valid && cfg_ready && (cfg_index == REG_TAP_COUNT)) begin
			taps_q <= cfg_data[CNT_W-1:0];
		end
	end

	assign taps       = sat_taps(taps_q, CNT_W'(TAPS_DEF));
	assign in_acc     = in_valid && !in_stall;
	assign in_hold    = in_valid && in_stall;
	assign out_hold   = out_valid && out_stall;
	assign tail_start = in_acc && block_end && (taps > CNT_W'(1));
	assign long_start = in_acc && block_end && (taps > CNT_W'(2));
	assign in_word    = {sample, block_end};
	assign out_word   = {filtered, final_res};

	`FCV_ASSERT_NEXT(a_out_valid_holds, clk, arst_n, out_hold, out_valid, "result dropped")
	`FCV_ASSERT_NEXT(a_out_stable, clk, arst_n, out_hold, $stable(out_word), "stalled result moved")
	`FCV_ASSERT_NEXT(a_in_stable, clk, arst_n, in_hold, in_valid && $stable(in_word), "input moved")
	`FCV_ASSERT_NEXT(a_tail_blocks_input, clk, arst_n, tail_start, in_stall, "input taken in tail")
	`FCV_ASSERT_NEXT(a_tail_long_blocks, clk, arst_n, long_start, ##1 in_stall, "tail ended early")

endmodule

bind fir_full_convolution fcv_chk u_fcv_chk (.*);

// ----- bench/fir_full_convolution_test.sv -----
// Self-checking bench for the full-convolution FIR filter: a directed table of
// extremes and corner cases, then random blocks under random input gaps and output stalls.
// Depends on fcv_pkg and fir_full_convolution.
module fir_full_convolution_test;
	import fcv_pkg::*;

	localparam int TAP_MAX     = TAPS_DEF;
	localparam int RAND_ITEMS  = 230;
	localparam int HOLD_CYCLES = 250;
	localparam int SETTLE      = 6;
	localparam int TAIL_WAIT   = 20;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PLAN_LEN    = 28;

	// Index past the register list; writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [COEF_WORD_W-1:0] data;
		logic [SAMPLE_PORT_W-1:0] smp;
		logic                   last;
		logic                   typed;
		logic [OUT_BITS-1:0]    exp_val;
		logic                   exp_final;
	} plan_row_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] value;
		logic                last;
	} conv_out_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [SAMPLE_PORT_W-1:0] sample;
	logic                     block_end;
	logic                     out_valid;
	logic                     out_stall;
	logic [OUT_BITS-1:0]      filtered;
	logic                     final_res;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [COEF_WORD_W-1:0]   cfg_data;

	// Predictor state: registers as written and the sample history
	logic [CNT_W-1:0]                tap_reg;
	logic [COEF_WORD_W-1:0]          coef_lo;
	logic [COEF_WORD_W-1:0]          coef_hi;
	logic signed [SAMPLE_PORT_W-1:0] hist [TAP_MAX-1];
	conv_out_t                       pending_q [$];

	int mismatch_cnt = 0;
	int cycle_cnt = 0;
	bit sender_quiet = 1'b0;
	bit receiver_quiet = 1'b0;
	bit hold_request = 1'b0;

	// Directed rows: typed expectations only where the value is obvious
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		// after reset: one tap, zero coefficient
		'{ROW_SAMPLE, REG_TAP_COUNT, 64'h0, 16'h7FFF, 1'b1, 1'b1, 35'sd0, 1'b1},
		'{ROW_CFG, REG_COEFFS_LOW, 64'h0000_0000_0000_8000, 16'h0, 1'b0, 1'b0, 35'sd0, 1'b0},
		'{ROW_SAMPLE, REG_TAP_COUNT, 64'h0, 16'h8000, 1'b1, 1'b1, 35'sd1073741824, 1'b1},
		'{ROW_SAMPLE, REG_TAP_COUNT, 64'h0, 16'h7FFF, 1'b1, 1'b1, -35'sd1073709056, 1'b1},
		// zero tap count acts as one; upper data bits are don't-care
		'{ROW_CFG, REG_TAP_COUNT, 64'hA5A5_0000_0000_0000, 16'h0, 1'b0, 1'b0, 35'sd0, 1'b0},
		'{ROW_SAMPLE, REG_TAP_COUNT, 64'h0, 16'h8000, 1'b0, 1'b1, 35'sd1073741824, 1'b0},
		'{ROW_SAMPLE, REG_TAP_COUNT, 64'h0, 16'h0001, 1'b1, 1'b1, -35'sd32768, 1'b1},
		// all coefficients most negative, count above the maximum
		'{ROW_CFG, REG_COEFFS_LOW, 64'h8000_8000_8000_8000, 16'h0, 1'b0, 1'b0, 35'sd0, 1'b0},
		'{ROW_CFG, REG_COEFFS_HIGH, 64'h8000_8000_8000_8000, 16'h0, 1'b0, 1'b0, 35'sd0, 1'b0},
		'{ROW_CFG, REG_TAP_COUNT, 64'h0000_0000_0000_000F, 16'h0, 1'b0, 1'b0, 35'sd0, 1'b0},
		'{ROW_SAMPLE, REG_TAP_COUNT, 64'h0, 16'h8000, 1'b0, 1'b0, 35'sd0, 1'b0},
		'{ROW_SAMPLE, REG_TAP_COUNT, 64'h0, 16'h8000, 1'b0, 1'b0, 35'sd0, 1'b0},
		'{ROW_SAMPLE, REG_TAP_COUNT, 64'h0, 16'h8000, 1'b0, 1'b0, 35'sd0, 1'b0},
		'{ROW_SAMPLE, REG_TAP_COUNT, 64'h0, 16'h8000, 1'b0, 1'b0, 35'sd0, 1'b0},
		'{ROW_SAMPLE, REG_TAP_COUNT, 64'h0, 16'h8000, 1'b0, 1'b0, 35'sd0, 1'b0},
		'{ROW_SAMPLE, REG_TAP_COUNT, 64'h0, 16'h8000, 1'b0, 1'b0, 35'sd0, 1'b0},
		'{ROW_SAMPLE, REG_TAP_COUNT, 64'h0, 16'h8000, 1'b0, 1'b0, 35'sd0, 1'b0},
		'{ROW_SAMPLE, REG_TAP_COUNT, 64'h0, 16'h8000, 1'b1, 1'b0, 35'sd0, 1'b0},
		// write past the register list is dropped
		'{ROW_CFG, REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 1'b0, 1'b0, 35'sd0, 1'b0},
		// mixed signs, then tap count raised in the middle of a block
		'{ROW_CFG, REG_TAP_COUNT, 64'h0000_0000_0000_0003, 16'h0, 1'b0, 1'b0, 35'sd0, 1'b0},
		'{ROW_CFG, REG_COEFFS_LOW, 64'h0000_7FFF_8000_7FFF, 16'h0, 1'b0, 1'b0, 35'sd0, 1'b0},
		'{ROW_SAMPLE, REG_TAP_COUNT, 64'h0, 16'h7FFF, 1'b0, 1'b0, 35'sd0, 1'b0},
		'{ROW_SAMPLE, REG_TAP_COUNT, 64'h0, 16'h8000, 1'b0, 1'b0, 35'sd0, 1'b0},
		'{ROW_SAMPLE, REG_TAP_COUNT, 64'h0, 16'h7FFF, 1'b0, 1'b0, 35'sd0, 1'b0},
		'{ROW_CFG, REG_TAP_COUNT, 64'h0000_0000_0000_0008, 16'h0, 1'b0, 1'b0, 35'sd0, 1'b0},
		'{ROW_SAMPLE, REG_TAP_COUNT, 64'h0, 16'h0000, 1'b1, 1'b0, 35'sd0, 1'b0},
		// single tap closing a block
		'{ROW_CFG, REG_TAP_COUNT, 64'h0000_0000_0000_0001, 16'h0, 1'b0, 1'b0, 35'sd0, 1'b0},
		'{ROW_SAMPLE, REG_TAP_COUNT, 64'h0, 16'h1234, 1'b1, 1'b0, 35'sd0, 1'b0}
	};

	fir_full_convolution DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.block_end (block_end),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.filtered  (filtered),
		.final_res (final_res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Signed coefficient k from the two packed words
	function automatic logic signed [COEF_BITS-1:0] coef_at(input int k);
		if (k < 4) begin
			return coef_lo[COEF_BITS*k +: COEF_BITS];
		end
		return coef_hi[COEF_BITS*(k-4) +: COEF_BITS];
	endfunction

	// One output of the convolution, then shift the sample into the history
	function automatic longint conv_step(input logic signed [SAMPLE_PORT_W-1:0] x,
			input int n_taps);
		longint acc;
		acc = longint'(coef_at(0)) * longint'(x);
		for (int k = 1; k < n_taps; k++) begin
			acc += longint'(coef_at(k)) * longint'(hist[k-1]);
		end
		for (int k = TAP_MAX - 2; k > 0; k--) begin
			hist[k] = hist[k-1];
		end
		hist[0] = x;
		return acc;
	endfunction

	// Queue the results one accepted item causes, tail included
	function automatic void predict_sample(input logic [SAMPLE_PORT_W-1:0] smp,
			input logic last, input logic typed, input logic [OUT_BITS-1:0] tv,
			input logic tf);
		int     n_taps;
		longint acc;
		n_taps = (tap_reg == 0) ? 1 : ((tap_reg > TAP_MAX) ? TAP_MAX : int'(tap_reg));
		acc = conv_step(smp, n_taps);
		if (typed) begin
			pending_q.push_back('{tv, tf});
		end else begin
			pending_q.push_back('{acc[OUT_BITS-1:0], last && (n_taps == 1)});
		end
		if (last) begin
			for (int j = 1; j < n_taps; j++) begin
				acc = conv_step('0, n_taps);
				pending_q.push_back('{acc[OUT_BITS-1:0], j == n_taps - 1});
			end
			foreach (hist[i]) hist[i] = '0;
		end
	endfunction

	// Four coefficients, extremes weighted in
	function automatic logic [COEF_WORD_W-1:0] pick_coeffs();
		logic [COEF_WORD_W-1:0] w;
		for (int k = 0; k < 4; k++) begin
			case ($urandom_range(7))
				0: w[COEF_BITS*k +: COEF_BITS] = 16'h8000;
				1: w[COEF_BITS*k +: COEF_BITS] = 16'h7FFF;
				2: w[COEF_BITS*k +: COEF_BITS] = 16'h0000;
				default: w[COEF_BITS*k +: COEF_BITS] = 16'($urandom);
			endcase
		end
		return w;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_cnt++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// Offer one item, with an occasional gap first; valid stays high afterwards
	task automatic send_sample(input logic [SAMPLE_PORT_W-1:0] smp, input logic last,
			input logic typed, input logic [OUT_BITS-1:0] tv, input logic tf);
		cfg_valid <= 1'b0;
		if (!sender_quiet && $urandom_range(99) < 25) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample    <= smp;
		block_end <= last;
		do @(posedge clk); while (in_stall);
		predict_sample(smp, last, typed, tv, tf);
	endtask

	// Register write; valid is dropped by the next send or idle wait
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [COEF_WORD_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_TAP_COUNT:   tap_reg = val[CNT_W-1:0];
			REG_COEFFS_LOW:  coef_lo = val;
			REG_COEFFS_HIGH: coef_hi = val;
			default: ;
		endcase
	endtask

	// Stop offering and let every outstanding result drain
	task automatic wait_idle();
		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Result side: random stalls, quiet stretches, one long hold-off on request
	initial begin : result_side
		int held;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				held = 0;
				while (held < HOLD_CYCLES) begin
					@(posedge clk);
					held++;
				end
				out_stall <= 1'b0;
			end else begin
				out_stall <= !receiver_quiet && ($urandom_range(99) < 38);
			end
		end
	end

	// Compare every accepted result with the oldest expectation
	always @(posedge clk) begin : out_check
		conv_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				report_mismatch($sformatf("unexpected item filtered=%0d final_res=%0b",
					$signed(filtered), final_res));
			end else begin
				want = pending_q.pop_front();
				if (filtered !== want.value) begin
					report_mismatch($sformatf("filtered=%0d, want %0d",
						$signed(filtered), $signed(want.value)));
				end
				if (final_res !== want.last) begin
					report_mismatch($sformatf("final_res=%0b, want %0b",
						final_res, want.last));
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		logic [SAMPLE_PORT_W-1:0] smp;
		logic [COEF_WORD_W-1:0]   word;
		int rand_items;
		int phase;
		int phase_len;
		int blk_pos;
		int blk_len;
		int tap_val;

		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		sample    <= '0;
		block_end <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_TAP_COUNT;
		cfg_data  <= '0;
		tap_reg = CNT_W'(1);
		coef_lo = '0;
		coef_hi = '0;
		foreach (hist[i]) hist[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int r = 0; r < PLAN_LEN; r++) begin
			if (PLAN[r].kind == ROW_CFG) begin
				wait_idle();
				write_reg(PLAN[r].idx, PLAN[r].data);
			end else begin
				send_sample(PLAN[r].smp, PLAN[r].last, PLAN[r].typed,
					PLAN[r].exp_val, PLAN[r].exp_final);
			end
		end

		// Random phases; blocks run on across phase boundaries
		rand_items = 0;
		phase = 0;
		blk_pos = 0;
		blk_len = 1;
		while (rand_items < RAND_ITEMS) begin
			wait_idle();
			sender_quiet   = (phase == 4);
			receiver_quiet = (phase == 4);
			case ($urandom_range(9))
				0: tap_val = 0;
				1: tap_val = $urandom_range(15, TAP_MAX + 1);
				2: tap_val = TAP_MAX;
				default: tap_val = $urandom_range(TAP_MAX, 1);
			endcase
			word = {$urandom, $urandom};
			word[CNT_W-1:0] = tap_val[CNT_W-1:0];
			write_reg(REG_TAP_COUNT, word);
			if (phase == 0 || $urandom_range(9) < 7) begin
				write_reg(REG_COEFFS_LOW, pick_coeffs());
			end
			if (phase == 0 || $urandom_range(9) < 7) begin
				write_reg(REG_COEFFS_HIGH, pick_coeffs());
			end
			if ($urandom_range(9) == 0) begin
				write_reg(REG_SPARE, {$urandom, $urandom});
			end
			// receiver backs off while samples keep coming
			if (phase == 2) begin
				hold_request = 1'b1;
			end
			phase_len = $urandom_range(28, 18);
			repeat (phase_len) begin
				if (blk_pos == 0) begin
					blk_len = ($urandom_range(7) == 0) ? 1 : $urandom_range(12, 1);
				end
				case ($urandom_range(9))
					0: smp = 16'h8000;
					1: smp = 16'h7FFF;
					2: smp = 16'h0000;
					default: smp = 16'($urandom);
				endcase
				send_sample(smp, blk_pos == blk_len - 1, 1'b0, '0, 1'b0);
				blk_pos = (blk_pos == blk_len - 1) ? 0 : blk_pos + 1;
				rand_items++;
			end
			phase++;
		end

		wait_idle();
		repeat (TAIL_WAIT) @(posedge clk);
		if (mismatch_cnt == 0 && pending_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/fcv_pkg.sv
hw/rtl/fir_full_convolution.sv
hw/rtl/fcv_chk.sv
bench/fir_full_convolution_test.sv
